// ===== hdl/tts_pkg.sv =====
// Shared constants and helpers for the tridiagonal Thomas solver.
// Depends on nothing; tts_mul, tts_div and the solver top level refer to it by scoped names.
package tts_pkg;

   // System size and number format.
   localparam int MAX_ROWS  = 64;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int ROW_OUT_W = 6;

   // Serial arithmetic unit sizes.
   localparam int MUL_CNT_W = $clog2(DATA_W);
   localparam int DIV_W     = DATA_W + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Saturate a 64-bit signed value to the signed 32-bit range.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/tts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/tts_mul.sv =====
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// Depends on tts_pkg for the data width and counter width.
module tts_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tts_pkg::DATA_W-1:0] x,
   input  logic signed [tts_pkg::DATA_W-1:0] y,
   output logic                              done,
   output logic signed [63:0]                product
);

   logic                            busy_ff, busy_in;
   logic                            fin_ff, fin_in;
   logic                            done_ff, done_in;
   logic [tts_pkg::MUL_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            neg_ff, neg_in;
   logic [tts_pkg::DATA_W-1:0]      mcand_ff, mcand_in;
   logic [tts_pkg::DATA_W-1:0]      hi_ff, hi_in;
   logic [tts_pkg::DATA_W-1:0]      lo_ff, lo_in;
   logic signed [63:0]              prod_ff, prod_in;
   logic [tts_pkg::DATA_W:0]        sum;

   assign done    = done_ff;
   assign product = prod_ff;

   // One shift-add step per cycle on the upper half of the accumulator.
   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      prod_in  = prod_ff;
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '1;
         neg_in   = x[tts_pkg::DATA_W-1] ^ y[tts_pkg::DATA_W-1];
         mcand_in = x[tts_pkg::DATA_W-1] ? -x : x;
         lo_in    = y[tts_pkg::DATA_W-1] ? -y : y;
         hi_in    = '0;
      end else if (busy_ff) begin
         hi_in  = sum[tts_pkg::DATA_W:1];
         lo_in  = {sum[0], lo_ff[tts_pkg::DATA_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         prod_in = neg_ff ? -$signed({hi_ff, lo_ff}) : $signed({hi_ff, lo_ff});
         done_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      prod_ff  <= prod_in;
   end

endmodule

// ===== hdl/tts_div.sv =====
// Bit-serial restoring divider giving a rounded, saturated fixed-point quotient.
// Depends on tts_pkg for widths and the fraction bit count.
module tts_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [tts_pkg::DATA_W:0]   num,
   input  logic signed [tts_pkg::DATA_W-1:0] den,
   output logic                              done,
   output logic signed [tts_pkg::DATA_W-1:0] quot
);

   localparam int W = tts_pkg::DIV_W;
   localparam int D = tts_pkg::DATA_W;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [tts_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 nneg_ff, nneg_in;
   logic                 nzero_ff, nzero_in;
   logic                 dzero_ff, dzero_in;
   logic [D-1:0]         dm_ff, dm_in;
   logic [D-1:0]         rem_ff, rem_in;
   logic [W-1:0]         q_ff, q_in;
   logic signed [D-1:0]  quot_ff, quot_in;
   logic [D:0]           num_mag;
   logic [D:0]           trial;
   logic                 up;
   logic [W:0]           qr;

   assign done = done_ff;
   assign quot = quot_ff;

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      nneg_in  = nneg_ff;
      nzero_in = nzero_ff;
      dzero_in = dzero_ff;
      dm_in    = dm_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      quot_in  = quot_ff;
      num_mag  = num[D] ? -num : num;
      trial    = {rem_ff, q_ff[W-1]};
      up       = ({rem_ff, 1'b0} >= {1'b0, dm_ff});
      qr       = {1'b0, q_ff} + {{W{1'b0}}, up};
      // Load operands as magnitudes; the dividend carries the fraction shift.
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = tts_pkg::DIV_CNT_W'(W - 1);
         neg_in   = num[D] ^ den[D-1];
         nneg_in  = num[D];
         nzero_in = (num == '0);
         dzero_in = (den == '0);
         dm_in    = den[D-1] ? -den : den;
         rem_in   = '0;
         q_in     = {num_mag[D-1:0], {tts_pkg::FRAC_BITS{1'b0}}};
      // One quotient bit per cycle.
      end else if (busy_ff) begin
         if (trial >= {1'b0, dm_ff}) begin
            rem_in = D'(trial - {1'b0, dm_ff});
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[D-1:0];
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      // Round half away from zero, apply the sign and saturate.
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (dzero_ff) begin
            if (nzero_ff) begin
               quot_in = '0;
            end else if (nneg_ff) begin
               quot_in = {1'b1, {(D-1){1'b0}}};
            end else begin
               quot_in = {1'b0, {(D-1){1'b1}}};
            end
         end else if (neg_ff) begin
            if ((|qr[W:D]) || (qr[D-1] && (|qr[D-2:0]))) begin
               quot_in = {1'b1, {(D-1){1'b0}}};
            end else begin
               quot_in = -$signed(qr[D-1:0]);
            end
         end else begin
            if (|qr[W:D-1]) begin
               quot_in = {1'b0, {(D-1){1'b1}}};
            end else begin
               quot_in = $signed(qr[D-1:0]);
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      nneg_ff  <= nneg_in;
      nzero_ff <= nzero_in;
      dzero_ff <= dzero_in;
      dm_ff    <= dm_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      quot_ff  <= quot_in;
   end

endmodule

// ===== hdl/tridiagonal_thomas_solver.sv =====
// Thomas solver top level. A row that is not the last stalls the input while its sweep
// step runs two 32-step serial multiplies and two 48-step serial divides, so a new row
// is taken only once the previous row is done. A last row gives its first solution
// beat after two multiplies and a divide, then one more beat per serial multiply down
// to row zero; a result stall holds a beat back. Synchronous active-high reset clears the
// row count, the carried coefficients and the singular flag; the RAMs are not cleared.
module tridiagonal_thomas_solver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [tts_pkg::DATA_W-1:0] req_sub_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_main_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_super_diag,
   input  logic signed [tts_pkg::DATA_W-1:0] req_rhs,
   input  logic                              req_is_last_row,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [tts_pkg::DATA_W-1:0] rsp_solution,
   output logic [tts_pkg::ROW_OUT_W-1:0]     rsp_row_index,
   output logic                              rsp_last_result,
   output logic                              rsp_singular
);

   localparam int D = tts_pkg::DATA_W;
   localparam int R = tts_pkg::ROW_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL_A = 4'd1;
   localparam logic [3:0] S_DEN   = 4'd2;
   localparam logic [3:0] S_MUL_B = 4'd3;
   localparam logic [3:0] S_NUM   = 4'd4;
   localparam logic [3:0] S_DIV_A = 4'd5;
   localparam logic [3:0] S_DIV_B = 4'd6;
   localparam logic [3:0] S_DIV_X = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;
   localparam logic [3:0] S_RDW   = 4'd9;
   localparam logic [3:0] S_MUL_V = 4'd10;
   localparam logic [3:0] S_ACC   = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [R-1:0]        row_count_ff, row_count_in;
   logic signed [D-1:0] prev_alpha_ff, prev_alpha_in;
   logic signed [D-1:0] prev_beta_ff, prev_beta_in;
   logic                sing_ff, sing_in;
   logic                mul_go_ff, mul_go_in;
   logic                div_go_ff, div_go_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic signed [D-1:0] a_ff, a_in;
   logic signed [D-1:0] c_ff, c_in;
   logic signed [D-1:0] b_ff, b_in;
   logic signed [D-1:0] g_ff, g_in;
   logic                last_ff, last_in;
   logic [R-1:0]        i_ff, i_in;
   logic signed [63:0]  rnd_ff, rnd_in;
   logic signed [D-1:0] den_ff, den_in;
   logic signed [D-1:0] num_ff, num_in;
   logic signed [D-1:0] alpha_ff, alpha_in;
   logic signed [D-1:0] beta_ff, beta_in;
   logic signed [D-1:0] v_ff, v_in;
   logic [R-1:0]        k_ff, k_in;
   logic signed [D-1:0] mx_ff, mx_in;
   logic signed [D-1:0] my_ff, my_in;
   logic signed [D:0]   dn_ff, dn_in;
   logic signed [D-1:0] dd_ff, dd_in;
   logic signed [D-1:0] sol_ff, sol_in;
   logic [R-1:0]        idx_ff, idx_in;
   logic                lres_ff, lres_in;
   logic                rsing_ff, rsing_in;

   logic                accept;
   logic                slot_free;
   logic                mul_done;
   logic signed [63:0]  mul_p;
   logic signed [63:0]  psum;
   logic                div_done;
   logic signed [D-1:0] div_q;
   logic                ram_wr;
   logic                ram_rd;
   logic [R-1:0]        rd_addr;
   logic [D-1:0]        alpha_rd;
   logic [D-1:0]        beta_rd;

   assign req_stall       = (state_ff != S_IDLE);
   assign accept          = req_valid && !req_stall;
   assign slot_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_solution    = sol_ff;
   assign rsp_row_index   = tts_pkg::ROW_OUT_W'(idx_ff);
   assign rsp_last_result = lres_ff;
   assign rsp_singular    = rsing_ff;

   // Rounded product: add half an LSB, then shift arithmetically.
   assign psum = mul_p + (64'sd1 <<< (tts_pkg::FRAC_BITS - 1));

   // Coefficient writes at the end of a sweep step; reads during back substitution.
   assign ram_wr  = (state_ff == S_DIV_B) && div_done;
   assign ram_rd  = (state_ff == S_EMIT) && slot_free && (k_ff != '0);
   assign rd_addr = k_ff - 1'b1;

   tts_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go_ff),
      .x       (mx_ff),
      .y       (my_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   tts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (dn_ff),
      .den   (dd_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   tts_ram #(.WIDTH(D), .DEPTH(tts_pkg::MAX_ROWS)) u_alpha_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (i_ff),
      .wr_data (alpha_ff),
      .rd_en   (ram_rd),
      .rd_addr (rd_addr),
      .rd_data (alpha_rd)
   );

   tts_ram #(.WIDTH(D), .DEPTH(tts_pkg::MAX_ROWS)) u_beta_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (i_ff),
      .wr_data (div_q),
      .rd_en   (ram_rd),
      .rd_addr (rd_addr),
      .rd_data (beta_rd)
   );

   // Row sequencer: forward sweep step, then back substitution on the last row.
   always_comb begin
      state_in      = state_ff;
      row_count_in  = row_count_ff;
      prev_alpha_in = prev_alpha_ff;
      prev_beta_in  = prev_beta_ff;
      sing_in       = sing_ff;
      mul_go_in     = 1'b0;
      div_go_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      a_in          = a_ff;
      c_in          = c_ff;
      b_in          = b_ff;
      g_in          = g_ff;
      last_in       = last_ff;
      i_in          = i_ff;
      rnd_in        = rnd_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      alpha_in      = alpha_ff;
      beta_in       = beta_ff;
      v_in          = v_ff;
      k_in          = k_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      dn_in         = dn_ff;
      dd_in         = dd_ff;
      sol_in        = sol_ff;
      idx_in        = idx_ff;
      lres_in       = lres_ff;
      rsing_in      = rsing_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               a_in      = (row_count_ff == '0) ? '0 : req_sub_diag;
               c_in      = req_main_diag;
               b_in      = req_super_diag;
               g_in      = req_rhs;
               last_in   = req_is_last_row || (row_count_ff == R'(tts_pkg::MAX_ROWS - 1));
               i_in      = row_count_ff;
               mx_in     = (row_count_ff == '0) ? '0 : req_sub_diag;
               my_in     = prev_alpha_ff;
               mul_go_in = 1'b1;
               state_in  = S_MUL_A;
            end
         end
         S_MUL_A: begin
            if (mul_done) begin
               rnd_in   = psum >>> tts_pkg::FRAC_BITS;
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            den_in    = tts_pkg::sat32(rnd_ff + 64'(c_ff));
            mx_in     = a_ff;
            my_in     = prev_beta_ff;
            mul_go_in = 1'b1;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            if (mul_done) begin
               rnd_in   = psum >>> tts_pkg::FRAC_BITS;
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            num_in    = tts_pkg::sat32(64'(g_ff) - rnd_ff);
            if (den_ff == '0) begin
               sing_in = 1'b1;
            end
            dd_in     = den_ff;
            div_go_in = 1'b1;
            if (last_ff) begin
               dn_in    = (D+1)'(tts_pkg::sat32(64'(g_ff) - rnd_ff));
               state_in = S_DIV_X;
            end else begin
               dn_in    = -(D+1)'(b_ff);
               state_in = S_DIV_A;
            end
         end
         S_DIV_A: begin
            if (div_done) begin
               alpha_in  = div_q;
               dn_in     = (D+1)'(num_ff);
               div_go_in = 1'b1;
               state_in  = S_DIV_B;
            end
         end
         S_DIV_B: begin
            if (div_done) begin
               prev_alpha_in = alpha_ff;
               prev_beta_in  = div_q;
               row_count_in  = i_ff + 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DIV_X: begin
            if (div_done) begin
               v_in     = div_q;
               k_in     = i_ff;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               sol_in       = v_ff;
               idx_in       = k_ff;
               lres_in      = (k_ff == '0);
               rsing_in     = sing_ff;
               if (k_ff == '0) begin
                  row_count_in  = '0;
                  prev_alpha_in = '0;
                  prev_beta_in  = '0;
                  sing_in       = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  k_in     = k_ff - 1'b1;
                  state_in = S_RDW;
               end
            end
         end
         S_RDW: begin
            mx_in     = alpha_rd;
            my_in     = v_ff;
            beta_in   = beta_rd;
            mul_go_in = 1'b1;
            state_in  = S_MUL_V;
         end
         S_MUL_V: begin
            if (mul_done) begin
               rnd_in   = psum >>> tts_pkg::FRAC_BITS;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            v_in     = tts_pkg::sat32(rnd_ff + 64'(beta_ff));
            state_in = S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_count_ff  <= '0;
         prev_alpha_ff <= '0;
         prev_beta_ff  <= '0;
         sing_ff       <= 1'b0;
         mul_go_ff     <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_count_ff  <= row_count_in;
         prev_alpha_ff <= prev_alpha_in;
         prev_beta_ff  <= prev_beta_in;
         sing_ff       <= sing_in;
         mul_go_ff     <= mul_go_in;
         div_go_ff     <= div_go_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      c_ff     <= c_in;
      b_ff     <= b_in;
      g_ff     <= g_in;
      last_ff  <= last_in;
      i_ff     <= i_in;
      rnd_ff   <= rnd_in;
      den_ff   <= den_in;
      num_ff   <= num_in;
      alpha_ff <= alpha_in;
      beta_ff  <= beta_in;
      v_ff     <= v_in;
      k_ff     <= k_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      dn_ff    <= dn_in;
      dd_ff    <= dd_in;
      sol_ff   <= sol_in;
      idx_ff   <= idx_in;
      lres_ff  <= lres_in;
      rsing_ff <= rsing_in;
   end

endmodule
